>>> hdl/ptxl_pkg.sv
package ptxl_pkg;

	localparam int LINE_W      = 24;
	localparam int POS_W       = 32;
	localparam int VAL_W       = 63;
	localparam int DIGIT_LIMIT = 31;
	localparam int DCNT_W      = 5;
	localparam int FCNT_W      = 4;
	localparam int MAX_TOK     = 3;
	localparam int Q_DEPTH     = 8;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = Q_PTR_W + 1;

	localparam logic [VAL_W-1:0]  VALUE_MAX = {VAL_W{1'b1}};
	localparam logic [LINE_W-1:0] LINE_MAX  = {LINE_W{1'b1}};

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	typedef enum logic [4:0] {
		K_NEWLINE = 5'd0,
		K_COMMA   = 5'd1,
		K_SEMI    = 5'd2,
		K_COLON   = 5'd3,
		K_LPAREN  = 5'd4,
		K_RPAREN  = 5'd5,
		K_LBRACE  = 5'd6,
		K_RBRACE  = 5'd7,
		K_LBRACK  = 5'd8,
		K_RBRACK  = 5'd9,
		K_PERCENT = 5'd10,
		K_DOT     = 5'd11,
		K_AT      = 5'd12,
		K_AT_NOT  = 5'd13,
		K_LABEL   = 5'd14,
		K_FLOAT   = 5'd15,
		K_HEX     = 5'd16,
		K_DEC     = 5'd17,
		K_IDENT   = 5'd18,
		K_EOF     = 5'd19
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_SLASH  = 4'd1,
		M_LINE   = 4'd2,
		M_BLOCK  = 4'd3,
		M_AT     = 4'd4,
		M_LABEL  = 4'd5,
		M_IDENT  = 4'd6,
		M_ZERO   = 4'd7,
		M_FLOAT  = 4'd8,
		M_XPRE   = 4'd9,
		M_HEXNUM = 4'd10,
		M_DECNUM = 4'd11
	} mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [4:0]        token_kind;
		logic [LINE_W-1:0] line_number;
		logic [VAL_W-1:0]  token_value;
		logic [POS_W-1:0]  text_start;
		logic [POS_W-1:0]  text_length;
		logic              last_of_run;
	} out_word_t;

	// tokens made by one byte, handed to the queue
	typedef struct packed {
		logic [1:0]                  cnt;
		out_word_t [MAX_TOK-1:0]     tok;
	} push_t;

	typedef struct packed {
		logic [VAL_W-1:0]  acc;
		logic              sat;
		logic [DCNT_W-1:0] dcnt;
	} num_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic id_start(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
			|| (c == CH_USCORE);
	endfunction

	function automatic logic id_cont(input logic [7:0] c);
		return id_start(c) || is_digit(c);
	endfunction

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (is_digit(c)) begin
			r.val = 4'(c - CH_0);
		end else if ((c >= CH_LA) && (c <= CH_LF)) begin
			r.val = 4'(c - CH_LA + 8'd10);
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			r.val = 4'(c - CH_UA + 8'd10);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// one digit into the accumulator, saturating at the largest value
	function automatic num_t add_digit(input num_t s, input logic [3:0] d,
		input logic is_hex);
		num_t r;
		logic [VAL_W+3:0] prod;
		r = s;
		prod = '0;
		if (s.dcnt < DCNT_W'(DIGIT_LIMIT)) begin
			r.dcnt = s.dcnt + 1'b1;
			if (!s.sat) begin
				if (is_hex) begin
					prod = {s.acc, 4'b0000} + (VAL_W+4)'(d);
				end else begin
					prod = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0}
						+ (VAL_W+4)'(d);
				end
				if (prod[VAL_W+3:VAL_W] != 4'd0) begin
					r.acc = VALUE_MAX;
					r.sat = 1'b1;
				end else begin
					r.acc = prod[VAL_W-1:0];
				end
			end
		end
		return r;
	endfunction

	function automatic out_word_t mk_tok(input kind_t k, input logic [LINE_W-1:0] ln,
		input logic [VAL_W-1:0] v, input logic [POS_W-1:0] st,
		input logic [POS_W-1:0] len);
		out_word_t t;
		t.token_kind  = k;
		t.line_number = ln;
		t.token_value = v;
		t.text_start  = st;
		t.text_length = len;
		t.last_of_run = 1'b0;
		return t;
	endfunction

endpackage

>>> hdl/ptxl_scan.sv
module ptxl_scan
	import ptxl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_word_t word,
	output push_t    push
);

	mode_t             mode_q, mode_n;
	logic [LINE_W-1:0] line_q, line_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [POS_W-1:0]  start_q, start_n;
	num_t              num_q, num_n;
	logic [FCNT_W-1:0] fcnt_q, fcnt_n;
	logic              star_q, star_n;

	always_comb begin
		logic [7:0]       c;
		logic             consumed;
		logic [1:0]       n;
		hex_t             h;
		logic [POS_W-1:0] s;
		out_word_t [MAX_TOK-1:0] tk;
		num_t             zn;

		c        = word.end_of_text ? CH_NUL : word.char_code;
		h        = hex_val(c);
		consumed = 1'b0;
		n        = 2'd0;
		tk       = '0;
		s        = start_q + 1'b1;
		zn       = '0;
		mode_n   = mode_q;
		line_n   = line_q;
		pos_n    = pos_q;
		start_n  = start_q;
		num_n    = num_q;
		fcnt_n   = fcnt_q;
		star_n   = star_q;

		// finish or extend whatever construct is open
		unique case (mode_q)
			M_IDLE: consumed = 1'b0;
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_n = M_LINE;
					consumed = 1'b1;
				end else if (c == CH_STAR) begin
					mode_n = M_BLOCK;
					star_n = 1'b0;
					consumed = 1'b1;
				end else begin
					mode_n = M_IDLE;
				end
			end
			M_LINE: begin
				if (c == CH_NL) begin
					mode_n = M_IDLE;
				end else begin
					consumed = 1'b1;
				end
			end
			M_BLOCK: begin
				consumed = 1'b1;
				if (c == CH_NL) begin
					if (line_q != LINE_MAX) line_n = line_q + 1'b1;
					star_n = 1'b0;
				end else if ((c == CH_SLASH) && star_q) begin
					mode_n = M_IDLE;
					star_n = 1'b0;
				end else begin
					star_n = (c == CH_STAR);
				end
			end
			M_AT: begin
				mode_n = M_IDLE;
				if (c == CH_BANG) begin
					tk[n] = mk_tok(K_AT_NOT, line_q, '0, '0, '0);
					n = n + 2'd1;
					consumed = 1'b1;
				end else begin
					tk[n] = mk_tok(K_AT, line_q, '0, '0, '0);
					n = n + 2'd1;
				end
			end
			M_LABEL, M_IDENT: begin
				if (id_cont(c)) begin
					consumed = 1'b1;
				end else begin
					tk[n] = mk_tok((mode_q == M_LABEL) ? K_LABEL : K_IDENT, line_q, '0,
						start_q, pos_q - start_q);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_ZERO: begin
				if ((c == CH_LF) || (c == CH_UF)) begin
					num_n.acc = '0;
					fcnt_n = '0;
					mode_n = M_FLOAT;
					consumed = 1'b1;
				end else if ((c == CH_LX) || (c == CH_UX)) begin
					mode_n = M_XPRE;
					consumed = 1'b1;
				end else if (is_digit(c)) begin
					num_n = add_digit(num_q, h.val, 1'b0);
					mode_n = M_DECNUM;
					consumed = 1'b1;
				end else begin
					tk[n] = mk_tok(K_DEC, line_q, '0, '0, '0);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_FLOAT, M_XPRE: begin
				if (!h.ok) begin
					// not a number after all: zero, then a name from the letter
					tk[n] = mk_tok(K_DEC, line_q, '0, '0, '0);
					n = n + 2'd1;
					if (id_cont(c)) begin
						start_n = s;
						mode_n = M_IDENT;
						consumed = 1'b1;
					end else begin
						tk[n] = mk_tok(K_IDENT, line_q, '0, s, pos_q - s);
						n = n + 2'd1;
						mode_n = M_IDLE;
					end
				end else if (mode_q == M_FLOAT) begin
					num_n.acc = VAL_W'({num_q.acc[27:0], h.val});
					fcnt_n = fcnt_q + 1'b1;
					consumed = 1'b1;
					if (fcnt_n >= FCNT_W'(8)) begin
						tk[n] = mk_tok(K_FLOAT, line_q, num_n.acc, '0, '0);
						n = n + 2'd1;
						fcnt_n = '0;
						mode_n = M_IDLE;
					end
				end else begin
					num_n = add_digit(zn, h.val, 1'b1);
					mode_n = M_HEXNUM;
					consumed = 1'b1;
				end
			end
			M_HEXNUM: begin
				if (h.ok) begin
					num_n = add_digit(num_q, h.val, 1'b1);
					consumed = 1'b1;
				end else begin
					tk[n] = mk_tok(K_HEX, line_q, num_q.acc, '0, '0);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_DECNUM: begin
				if (is_digit(c)) begin
					num_n = add_digit(num_q, h.val, 1'b0);
					consumed = 1'b1;
				end else begin
					tk[n] = mk_tok(K_DEC, line_q, num_q.acc, '0, '0);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end
			end
			default: mode_n = M_IDLE;
		endcase

		if (word.end_of_text) begin
			tk[n] = mk_tok(K_EOF, line_q, '0, '0, '0);
			n = n + 2'd1;
			mode_n  = M_IDLE;
			line_n  = LINE_W'(1);
			pos_n   = '0;
			start_n = '0;
			num_n   = '0;
			fcnt_n  = '0;
			star_n  = 1'b0;
		end else begin
			if (!consumed) begin
				case (c)
					CH_SPACE, CH_TAB, CH_CR, CH_FF: ;
					CH_NL: begin
						tk[n] = mk_tok(K_NEWLINE, line_q, '0, '0, '0);
						n = n + 2'd1;
						if (line_q != LINE_MAX) line_n = line_q + 1'b1;
					end
					CH_COMMA: begin tk[n] = mk_tok(K_COMMA, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_SEMI:  begin tk[n] = mk_tok(K_SEMI, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_COLON: begin tk[n] = mk_tok(K_COLON, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_LPAR:  begin tk[n] = mk_tok(K_LPAREN, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_RPAR:  begin tk[n] = mk_tok(K_RPAREN, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_LBRC:  begin tk[n] = mk_tok(K_LBRACE, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_RBRC:  begin tk[n] = mk_tok(K_RBRACE, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_LBRK:  begin tk[n] = mk_tok(K_LBRACK, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_RBRK:  begin tk[n] = mk_tok(K_RBRACK, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_PCT:   begin tk[n] = mk_tok(K_PERCENT, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_DOT:   begin tk[n] = mk_tok(K_DOT, line_q, '0, '0, '0); n = n + 2'd1; end
					CH_SLASH: mode_n = M_SLASH;
					CH_AT:    mode_n = M_AT;
					CH_DOLLAR: begin
						start_n = pos_q;
						mode_n = M_LABEL;
					end
					default: begin
						if (is_digit(c)) begin
							start_n = pos_q;
							num_n = add_digit(zn, h.val, 1'b0);
							mode_n = (c == CH_0) ? M_ZERO : M_DECNUM;
						end else if (id_start(c)) begin
							start_n = pos_q;
							mode_n = M_IDENT;
						end
					end
				endcase
			end
			pos_n = pos_q + 1'b1;
		end

		for (int i = 0; i < MAX_TOK; i++) begin
			tk[i].last_of_run = (n != 2'd0) && (2'(i) == n - 2'd1);
		end
		push.cnt = fire ? n : 2'd0;
		push.tok = tk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= LINE_W'(1);
			pos_q   <= '0;
			start_q <= '0;
			num_q   <= '0;
			fcnt_q  <= '0;
			star_q  <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_n;
			line_q  <= line_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			num_q   <= num_n;
			fcnt_q  <= fcnt_n;
			star_q  <= star_n;
		end
	end

endmodule

>>> hdl/ptxl_queue.sv
module ptxl_queue
	import ptxl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      room,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_word_t tok_word
);

	out_word_t          mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q, rp_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               pop;

	assign room      = cnt_q <= Q_CNT_W'(Q_DEPTH - MAX_TOK);
	assign tok_valid = cnt_q != '0;
	assign tok_word  = mem[rp_q];
	assign pop       = tok_valid && tok_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOK; i++) begin
			if (2'(i) < push.cnt) mem[wp_q + Q_PTR_W'(i)] <= push.tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + Q_PTR_W'(push.cnt);
			rp_q  <= rp_q + Q_PTR_W'(pop);
			cnt_q <= cnt_q + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("token queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room) else $error("tokens pushed without room");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("token count did not drop on pop");

endmodule

>>> hdl/ptx_token_lexer_core.sv
// ptx assembly lexer: takes one source byte per word on src, or an end word, and
// sends tokens on tok. a byte is taken every cycle while the token queue has room
// for three more tokens; the per-byte scan is a single pass of logic from the lexer
// state registers into an eight-entry token queue, and tokens leave at one per
// cycle while tok_ready is high. a byte completes zero to three tokens (for
// example "0f1" then newline gives 0, identifier, newline); last_of_run marks
// the final token of each word. labels and identifiers are reported by byte
// offset and length, never copied. the end word flushes the open token, sends
// eof and returns the lexer to its reset state, with line one and offset zero.
module ptx_token_lexer_core
	import ptxl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_word_t  src_word,
	output logic      tok_valid,
	input  logic      tok_ready,
	output out_word_t tok_word
);

	logic  fire;
	push_t push;

	// a byte is taken whenever src offers one and at least three free queue entries are left
	assign fire = src_valid && src_ready;

	ptxl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (src_word),
		.push   (push)
	);

	// the token queue is the result side; it drains independent of src
	ptxl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (src_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_word  (tok_word)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ptxl_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	in_word_t  src_word;
	logic      tok_valid;
	logic      tok_ready;
	out_word_t tok_word;

	ptx_token_lexer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_word (src_word),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_word (tok_word)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// lexer shadow state
	mode_t             sh_mode;
	logic [LINE_W-1:0] sh_line;
	logic [POS_W-1:0]  sh_pos;
	logic [POS_W-1:0]  sh_start;
	logic [VAL_W-1:0]  sh_acc;
	logic              sh_sat;
	int unsigned       sh_dcnt;
	int unsigned       sh_fcnt;
	logic              sh_star;

	out_word_t token_fifo[$];
	in_word_t  byte_fifo[$];
	out_word_t step_toks[$];
	int        src_hold;   // byte index at which the sender waits for a drain
	int        bytes_taken;
	int        mismatches;
	int        tokens_seen;
	int        eofs_seen;
	bit        stim_done;

	function automatic bit is_idc(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_"
			|| (c >= "0" && c <= "9");
	endfunction

	function automatic int hexdig(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void push_tok(kind_t k, logic [VAL_W-1:0] v,
		logic [POS_W-1:0] st, logic [POS_W-1:0] len);
		out_word_t t;
		t.token_kind  = k;
		t.line_number = sh_line;
		t.token_value = v;
		t.text_start  = st;
		t.text_length = len;
		t.last_of_run = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void bump_line();
		if (sh_line != {LINE_W{1'b1}}) sh_line = sh_line + 1'b1;
	endfunction

	// saturating accumulate of one digit, digits past the limit dropped
	function automatic void acc_digit(int d, int base);
		logic [VAL_W+4:0] p;
		if (sh_dcnt >= DIGIT_LIMIT) return;
		sh_dcnt++;
		if (sh_sat) return;
		p = sh_acc * base + d;
		if (p > {VAL_W{1'b1}}) begin
			sh_acc = {VAL_W{1'b1}};
			sh_sat = 1'b1;
		end else begin
			sh_acc = p[VAL_W-1:0];
		end
	endfunction

	function automatic void clear_lexer();
		sh_mode  = M_IDLE;
		sh_line  = 1;
		sh_pos   = 0;
		sh_start = 0;
		sh_acc   = 0;
		sh_sat   = 0;
		sh_dcnt  = 0;
		sh_fcnt  = 0;
		sh_star  = 0;
	endfunction

	// "0f" short of eight digits, or bare "0x": zero then identifier from byte 2
	function automatic bit fall_back(logic [7:0] c, logic [POS_W-1:0] p);
		logic [POS_W-1:0] s;
		s = sh_start + 1'b1;
		push_tok(K_DEC, 0, 0, 0);
		if (is_idc(c)) begin
			sh_start = s;
			sh_mode  = M_IDENT;
			return 1;
		end
		push_tok(K_IDENT, 0, s, p - s);
		sh_mode = M_IDLE;
		return 0;
	endfunction

	// returns 1 when the open construct swallowed the byte
	function automatic bit feed_open(logic [7:0] c, logic [POS_W-1:0] p);
		int h;
		h = hexdig(c);
		case (sh_mode)
			M_IDLE: return 0;
			M_SLASH: begin
				if (c == "/") begin sh_mode = M_LINE; return 1; end
				if (c == "*") begin sh_mode = M_BLOCK; sh_star = 0; return 1; end
				sh_mode = M_IDLE;
				return 0;
			end
			M_LINE: begin
				if (c == CH_NL) begin sh_mode = M_IDLE; return 0; end
				return 1;
			end
			M_BLOCK: begin
				if (c == CH_NL) begin
					bump_line();
					sh_star = 0;
				end else if (c == "/" && sh_star) begin
					sh_mode = M_IDLE;
					sh_star = 0;
				end else begin
					sh_star = (c == "*");
				end
				return 1;
			end
			M_AT: begin
				sh_mode = M_IDLE;
				if (c == "!") begin push_tok(K_AT_NOT, 0, 0, 0); return 1; end
				push_tok(K_AT, 0, 0, 0);
				return 0;
			end
			M_LABEL, M_IDENT: begin
				if (is_idc(c)) return 1;
				push_tok(sh_mode == M_LABEL ? K_LABEL : K_IDENT, 0, sh_start,
					p - sh_start);
				sh_mode = M_IDLE;
				return 0;
			end
			M_ZERO: begin
				if (c == "f" || c == "F") begin
					sh_acc = 0;
					sh_fcnt = 0;
					sh_mode = M_FLOAT;
					return 1;
				end
				if (c == "x" || c == "X") begin sh_mode = M_XPRE; return 1; end
				if (c >= "0" && c <= "9") begin
					acc_digit(c - "0", 10);
					sh_mode = M_DECNUM;
					return 1;
				end
				push_tok(K_DEC, 0, 0, 0);
				sh_mode = M_IDLE;
				return 0;
			end
			M_FLOAT: begin
				if (h < 0) return fall_back(c, p);
				sh_acc = {sh_acc[27:0], 4'(h)} & 63'hFFFF_FFFF;
				sh_fcnt++;
				if (sh_fcnt >= 8) begin
					push_tok(K_FLOAT, sh_acc, 0, 0);
					sh_fcnt = 0;
					sh_mode = M_IDLE;
				end
				return 1;
			end
			M_XPRE: begin
				if (h < 0) return fall_back(c, p);
				sh_acc = 0;
				sh_sat = 0;
				sh_dcnt = 0;
				acc_digit(h, 16);
				sh_mode = M_HEXNUM;
				return 1;
			end
			M_HEXNUM: begin
				if (h >= 0) begin acc_digit(h, 16); return 1; end
				push_tok(K_HEX, sh_acc, 0, 0);
				sh_mode = M_IDLE;
				return 0;
			end
			M_DECNUM: begin
				if (c >= "0" && c <= "9") begin acc_digit(c - "0", 10); return 1; end
				push_tok(K_DEC, sh_acc, 0, 0);
				sh_mode = M_IDLE;
				return 0;
			end
			default: begin
				sh_mode = M_IDLE;
				return 0;
			end
		endcase
	endfunction

	function automatic void scan_fresh(logic [7:0] c, logic [POS_W-1:0] p);
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_FF: return;
			CH_NL: begin push_tok(K_NEWLINE, 0, 0, 0); bump_line(); return; end
			CH_COMMA: begin push_tok(K_COMMA, 0, 0, 0); return; end
			CH_SEMI: begin push_tok(K_SEMI, 0, 0, 0); return; end
			CH_COLON: begin push_tok(K_COLON, 0, 0, 0); return; end
			CH_LPAR: begin push_tok(K_LPAREN, 0, 0, 0); return; end
			CH_RPAR: begin push_tok(K_RPAREN, 0, 0, 0); return; end
			CH_LBRC: begin push_tok(K_LBRACE, 0, 0, 0); return; end
			CH_RBRC: begin push_tok(K_RBRACE, 0, 0, 0); return; end
			CH_LBRK: begin push_tok(K_LBRACK, 0, 0, 0); return; end
			CH_RBRK: begin push_tok(K_RBRACK, 0, 0, 0); return; end
			CH_PCT: begin push_tok(K_PERCENT, 0, 0, 0); return; end
			CH_DOT: begin push_tok(K_DOT, 0, 0, 0); return; end
			CH_SLASH: begin sh_mode = M_SLASH; return; end
			CH_AT: begin sh_mode = M_AT; return; end
			CH_DOLLAR: begin sh_start = p; sh_mode = M_LABEL; return; end
			default: ;
		endcase
		if (c >= "0" && c <= "9") begin
			sh_start = p;
			sh_acc = 0;
			sh_sat = 0;
			sh_dcnt = 0;
			acc_digit(c - "0", 10);
			sh_mode = (c == "0") ? M_ZERO : M_DECNUM;
		end else if (is_idc(c)) begin
			sh_start = p;
			sh_mode = M_IDENT;
		end
	endfunction

	// works out the tokens one accepted word completes
	function automatic void lex_word(in_word_t w);
		logic [POS_W-1:0] p;
		out_word_t t;
		p = sh_pos;
		step_toks.delete();
		if (w.end_of_text) begin
			void'(feed_open(8'h00, p));
			push_tok(K_EOF, 0, 0, 0);
			clear_lexer();
		end else begin
			if (!feed_open(w.char_code, p)) scan_fresh(w.char_code, p);
			sh_pos = p + 1'b1;
		end
		if (step_toks.size() > 0) begin
			t = step_toks.pop_back();
			t.last_of_run = 1'b1;
			step_toks.push_back(t);
		end
		foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
	endfunction

	// stimulus helpers
	function automatic void put_ch(logic [7:0] c);
		in_word_t w;
		w.char_code = c;
		w.end_of_text = 1'b0;
		byte_fifo.push_back(w);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) put_ch(s[i]);
	endfunction

	function automatic void put_end();
		in_word_t w;
		w.char_code = 8'($urandom);
		w.end_of_text = 1'b1;
		byte_fifo.push_back(w);
	endfunction

	function automatic string rnd_word();
		string s;
		string pool;
		int n;
		pool = "abcdefxyzABCFXZ_0123456789";
		n = $urandom_range(1, 6);
		s = "";
		for (int i = 0; i < n; i++) s = {s, pool.substr(i == 0 ? 0 : 0,
			i == 0 ? 0 : 0)};
		s = "";
		for (int i = 0; i < n; i++) begin
			int k;
			k = (i == 0) ? $urandom_range(0, 15) : $urandom_range(0, 25);
			s = {s, string'(pool[k])};
		end
		return s;
	endfunction

	function automatic string rnd_digits(int n, bit hex);
		string s;
		string pool;
		pool = "0123456789abcdefABCDEF";
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(pool[hex ? $urandom_range(0, 21) : $urandom_range(0, 9)])};
		return s;
	endfunction

	// well-formed ptx-like fragments with random content, and some noise
	function automatic void put_fragment();
		case ($urandom_range(0, 15))
			0: put_str({rnd_word(), " "});
			1: put_str({"%r", rnd_digits($urandom_range(1, 3), 0), ","});
			2: put_str({"0x", rnd_digits($urandom_range(0, 20), 1), " "});
			3: put_str({"0f", rnd_digits($urandom_range(0, 9), 1), ";"});
			4: put_str({rnd_digits($urandom_range(1, 24), 0), "]"});
			5: put_str({"$L", rnd_word(), ":\n"});
			6: put_str($urandom_range(0, 1) ? "@!p " : "@p ");
			7: put_str({"// ", rnd_word(), "\n"});
			8: put_str({"/* ", rnd_word(), "\n*", "*/"});
			9: put_str(".reg .b32 {%r1}, [x+4];\n");
			10: put_ch(8'($urandom));
			11: put_str("/ (\t\r\f)");
			12: put_str({"0", rnd_word()});
			13: put_str("0X7F 0F3f800000\n");
			14: put_str("@");
			default: put_str("\n");
		endcase
	endfunction

	// driver
	int src_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_word  <= '0;
			src_wait  <= 0;
			bytes_taken <= 0;
		end else begin
			if (src_valid && src_ready) begin
				lex_word(src_word);
				bytes_taken <= bytes_taken + 1;
			end
			if (!src_valid || src_ready) begin
				if (src_wait > 0) begin
					src_valid <= 1'b0;
					src_wait  <= src_wait - 1;
				end else if (byte_fifo.size() > 0 && !(bytes_taken + (src_valid && src_ready)
					== src_hold && token_fifo.size() > 0)) begin
					src_valid <= 1'b1;
					src_word  <= byte_fifo.pop_front();
					src_wait  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	int snk_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ready <= 1'b0;
			snk_wait  <= 0;
		end else begin
			if (tok_valid && tok_ready) begin
				out_word_t want;
				tokens_seen++;
				if (tok_word.token_kind == K_EOF) eofs_seen++;
				if (token_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token word %p", tok_word);
				end else begin
					want = token_fifo.pop_front();
					if (tok_word !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: expected %p, got %p", want, tok_word);
					end
				end
			end
			if (snk_wait > 0) begin
				tok_ready <= 1'b0;
				snk_wait  <= snk_wait - 1;
			end else begin
				tok_ready <= 1'b1;
				snk_wait  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
			end
		end
	end

	// watchdog on cycles without any accepted word
	int idle_cycles;
	always @(posedge clk) begin
		if ((src_valid && src_ready) || (tok_valid && tok_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		src_hold = -1;
		mismatches = 0;
		tokens_seen = 0;
		eofs_seen = 0;
		idle_cycles = 0;
		clear_lexer();
		// directed: every punctuation, at forms, numbers, comments, bytes 1, 255 and 128
		put_str(",;:(){}[]%.\n@!@x$_L9 id_Z");
		put_str(" 0f3F800000 0f12z 0x 0xFFFFFFFFFFFFFFFFFFFF 99999999999999999999999");
		put_str(" 12345678901234567890123456789012345 0 07/a/* *\n*/");
		put_ch(8'h01);
		put_ch(8'hFF);
		put_ch(8'h80);
		put_str("//x\n0F1\t");
		put_end();
		put_str("abc");
		put_end();
		put_end();
		src_hold = byte_fifo.size();
		while (byte_fifo.size() < 350) begin
			put_fragment();
			if ($urandom_range(0, 30) == 0) put_end();
		end
		put_str("/* open comment\n never closed");
		put_end();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (byte_fifo.size() == 0 && !src_valid);
		wait (token_fifo.size() == 0);
		repeat (20) @(posedge clk);
		$display("fed %0d bytes, checked %0d tokens over %0d text runs",
			bytes_taken, tokens_seen, eofs_seen);
		if (mismatches == 0 && token_fifo.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
hdl/ptxl_pkg.sv
hdl/ptxl_scan.sv
hdl/ptxl_queue.sv
hdl/ptx_token_lexer_core.sv
dv/tb_top.sv
